FILE: rtl/can_bts_pkg.sv
// shared types, constants and timing table for the can bit timing solver
package can_bts_pkg;

    // width of the serial divider operands
    localparam int unsigned DIV_W = 32;
    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    // rate, quanta and prescaler limits and the reset clock frequency
    localparam logic [31:0] HIGH_RATE_HZ     = 32'd1000000;
    localparam logic [4:0]  QUANTA_HIGH_RATE = 5'd10;
    localparam logic [4:0]  QUANTA_NORMAL    = 5'd17;
    localparam logic [4:0]  QUANTA_MIN       = 5'd3;
    localparam logic [31:0] PRESCALER_MAX    = 32'd1024;
    localparam logic [31:0] CLOCK_RESET_HZ   = 32'd80000000;

    // status word of the serial divider
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIV_W-1:0]  remainder;
    } div_res_t;

    // segment split for one quanta count
    typedef struct packed {
        logic [4:0] seg1;
        logic [3:0] seg2;
        logic [9:0] sp;
    } seg_split_t;

    // segment split aiming at 87.5 percent, truncated when above 88.0 percent
    function automatic seg_split_t seg_lookup(input logic [4:0] quanta);
        seg_split_t s;
        s = '0;
        unique case (quanta)
            5'd3:    s = '{seg1: 5'd1,  seg2: 4'd1, sp: 10'd666};
            5'd4:    s = '{seg1: 5'd2,  seg2: 4'd1, sp: 10'd750};
            5'd5:    s = '{seg1: 5'd3,  seg2: 4'd1, sp: 10'd800};
            5'd6:    s = '{seg1: 5'd4,  seg2: 4'd1, sp: 10'd833};
            5'd7:    s = '{seg1: 5'd5,  seg2: 4'd1, sp: 10'd857};
            5'd8:    s = '{seg1: 5'd6,  seg2: 4'd1, sp: 10'd875};
            5'd9:    s = '{seg1: 5'd6,  seg2: 4'd2, sp: 10'd777};
            5'd10:   s = '{seg1: 5'd7,  seg2: 4'd2, sp: 10'd800};
            5'd11:   s = '{seg1: 5'd8,  seg2: 4'd2, sp: 10'd818};
            5'd12:   s = '{seg1: 5'd9,  seg2: 4'd2, sp: 10'd833};
            5'd13:   s = '{seg1: 5'd10, seg2: 4'd2, sp: 10'd846};
            5'd14:   s = '{seg1: 5'd11, seg2: 4'd2, sp: 10'd857};
            5'd15:   s = '{seg1: 5'd12, seg2: 4'd2, sp: 10'd866};
            5'd16:   s = '{seg1: 5'd13, seg2: 4'd2, sp: 10'd875};
            5'd17:   s = '{seg1: 5'd13, seg2: 4'd3, sp: 10'd823};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/can_bit_timing_solver.sv
// can bit timing solver: sequencer around one shared serial divider
// a zero rate finishes at once; otherwise one divider pass forms the product,
//   then quanta trials follow until the word is rejected at a trial or the
//   rate check runs, with at most 15 quanta trials
// one word at a time: the next is accepted in the cycle after the result is loaded
// reset: clock_reg returns to 80 MHz, sequencer idle, no result pending
module can_bit_timing_solver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] bit_rate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [10:0] prescaler,
    output logic [4:0]  seg1_quanta,
    output logic [3:0]  seg2_quanta,
    output logic [9:0]  sample_point_permille
);
    import can_bts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROD   = 3'd1;
    localparam logic [2:0] S_TRIAL  = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [31:0]      clock_reg;
    logic [31:0]      rate_reg, rate_next;
    logic [31:0]      product_reg, product_next;
    logic [4:0]       quanta_reg, quanta_next;
    logic [10:0]      pre_reg, pre_next;
    logic             res_ok_reg, res_ok_next;
    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [10:0]      out_pre_reg;
    logic [4:0]       out_seg1_reg;
    logic [3:0]       out_seg2_reg;
    logic [9:0]       out_sp_reg;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    div_res_t         div_res;
    seg_split_t       split;
    logic             out_load;

    can_bts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    // clock frequency register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_reg <= CLOCK_RESET_HZ;
        else if (cfg_wr_en)
            clock_reg <= cfg_wr_data;
    end

    assign split    = seg_lookup(quanta_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        rate_next    = rate_reg;
        product_next = product_reg;
        quanta_next  = quanta_reg;
        pre_next     = pre_reg;
        res_ok_next  = res_ok_reg;
        div_start    = 1'b0;
        div_dividend = clock_reg;
        div_divisor  = product_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rate_next   = bit_rate;
                    res_ok_next = 1'b0;
                    quanta_next = (bit_rate >= HIGH_RATE_HZ) ? QUANTA_HIGH_RATE
                                                             : QUANTA_NORMAL;
                    if (bit_rate == '0)
                        state_next = S_FINISH;
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = clock_reg;
                        div_divisor  = bit_rate;
                        state_next   = S_PROD;
                    end
                end
            end
            S_PROD:
            begin
                if (div_res.done)
                begin
                    product_next = div_res.quotient;
                    div_start    = 1'b1;
                    div_dividend = div_res.quotient;
                    div_divisor  = DIV_W'(quanta_reg);
                    state_next   = S_TRIAL;
                end
            end
            S_TRIAL:
            begin
                if (div_res.done)
                begin
                    if (div_res.remainder == '0)
                    begin
                        if (div_res.quotient == '0 || div_res.quotient > PRESCALER_MAX)
                            state_next = S_FINISH;
                        else
                        begin
                            pre_next     = div_res.quotient[10:0];
                            div_start    = 1'b1;
                            div_dividend = clock_reg;
                            div_divisor  = product_reg;
                            state_next   = S_CHECK;
                        end
                    end
                    else if (quanta_reg == QUANTA_MIN)
                        state_next = S_FINISH;
                    else
                    begin
                        quanta_next  = quanta_reg - 1'b1;
                        div_start    = 1'b1;
                        div_dividend = product_reg;
                        div_divisor  = DIV_W'(quanta_reg - 1'b1);
                    end
                end
            end
            S_CHECK:
            begin
                if (div_res.done)
                begin
                    res_ok_next = (div_res.quotient == rate_reg);
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            res_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            res_ok_reg <= res_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg    <= rate_next;
        product_reg <= product_next;
        quanta_reg  <= quanta_next;
        pre_reg     <= pre_next;
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ok_reg   <= res_ok_reg;
            out_pre_reg  <= res_ok_reg ? pre_reg : '0;
            out_seg1_reg <= res_ok_reg ? split.seg1 : '0;
            out_seg2_reg <= res_ok_reg ? split.seg2 : '0;
            out_sp_reg   <= res_ok_reg ? split.sp : '0;
        end
    end

    assign out_valid             = out_valid_reg;
    assign ok                    = out_ok_reg;
    assign prescaler             = out_pre_reg;
    assign seg1_quanta           = out_seg1_reg;
    assign seg2_quanta           = out_seg2_reg;
    assign sample_point_permille = out_sp_reg;

endmodule

FILE: rtl/can_bts_div.sv
// restoring serial divider, one quotient bit per cycle
module can_bts_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [can_bts_pkg::DIV_W-1:0]      dividend,
    input  logic [can_bts_pkg::DIV_W-1:0]      divisor,
    output can_bts_pkg::div_res_t              res
);
    import can_bts_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    // one trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        if (!diff[DIV_W])
        begin
            rem_next = diff[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign res.busy      = busy_reg;
    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

FILE: rtl/can_bts_checker.sv
// port-level checks for the can bit timing solver, bound to the top level
module can_bts_props (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] bit_rate,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        ok,
    input  logic [10:0] prescaler,
    input  logic [4:0]  seg1_quanta,
    input  logic [3:0]  seg2_quanta,
    input  logic [9:0]  sample_point_permille
);

    // a failed word carries all zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> prescaler == 11'd0 && seg1_quanta == 5'd0 &&
            seg2_quanta == 4'd0 && sample_point_permille == 10'd0)
        else $error("failed word with nonzero fields");

    // a good word stays within the timing limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> prescaler != 11'd0 && prescaler <= 11'd1024 &&
            seg1_quanta != 5'd0 && seg1_quanta <= 5'd16 &&
            seg2_quanta != 4'd0 && seg2_quanta <= 4'd8 &&
            sample_point_permille <= 10'd880)
        else $error("good word outside timing limits");

    // the solver is busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while solving");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(prescaler))
        else $error("stalled result changed");

endmodule

bind can_bit_timing_solver can_bts_props u_can_bts_props (.*);
